// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define APX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define APX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/apx_pkg.sv -----
package apx_pkg;

    localparam int MAX_PACKET = 256;
    localparam int IDX_W      = $clog2(MAX_PACKET);
    localparam int CNT_W      = $clog2(MAX_PACKET + 1);
    localparam int LEN_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int TICK_W     = 8;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 8'd12;

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_LOAD  = 2'd1,
        FN_XCHG  = 2'd2,
        FN_TICK  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ACK  = 2'd1,
        PH_BYTE = 2'd2
    } phase_t;

    typedef struct packed {
        func_t              func;
        logic [BYTE_W-1:0]  device_address;
        logic [BYTE_W-1:0]  data_byte;
        logic [LEN_W-1:0]   req_length;
        logic [LEN_W-1:0]   max_resp_length;
        logic               ack_seen;
    } item_t;

    typedef struct packed {
        logic               tx_valid;
        logic [BYTE_W-1:0]  tx_byte;
        logic               resp_valid;
        logic [BYTE_W-1:0]  resp_byte;
        logic               select_active;
        logic               done_res;
        logic [LEN_W-1:0]   resp_count;
    } result_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [BYTE_W-1:0]  wdata;
        logic [IDX_W-1:0]   raddr;
    } store_req_t;

    // Store index from a byte count, keeping the low IDX_W bits.
    function automatic logic [IDX_W-1:0] idx_of(input logic [LEN_W-1:0] v);
        return IDX_W'(v);
    endfunction

endpackage

// ----- rtl/apx_store.sv -----
module apx_store (
    input  logic                      clk,
    input  apx_pkg::store_req_t       req,
    input  logic                      rd_en,
    output logic [apx_pkg::BYTE_W-1:0] rd_data
);

    logic [apx_pkg::BYTE_W-1:0] mem [apx_pkg::MAX_PACKET];
    logic [apx_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // write-to-read bypass when both hit the same entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (req.we && (req.waddr == req.raddr))
            begin
                rd_data_reg <= req.wdata;
            end
            else
            begin
                rd_data_reg <= mem[req.raddr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/apx_ctrl.sv -----
module apx_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [apx_pkg::TICK_W-1:0] cfg_wr_data,
    input  apx_pkg::item_t             item,
    input  logic                       fire,
    input  logic [apx_pkg::BYTE_W-1:0] rd_data,
    output apx_pkg::result_t           result,
    output apx_pkg::store_req_t        store_req,
    output apx_pkg::phase_t            phase
);

    apx_pkg::phase_t            phase_reg, phase_next;
    logic [apx_pkg::CNT_W-1:0]  load_index_reg, load_index_next;
    logic [apx_pkg::LEN_W-1:0]  rc_reg, rc_next;
    logic [apx_pkg::LEN_W-1:0]  req_total_reg, req_total_next;
    logic [apx_pkg::LEN_W-1:0]  resp_limit_reg, resp_limit_next;
    logic [apx_pkg::TICK_W-1:0] ticks_reg, ticks_next;
    logic [apx_pkg::TICK_W-1:0] timeout_reg;

    logic start_ok, load_ok, xchg_ok, tick_ok;
    logic ack_send, ack_end, timeout_end, done;
    logic [apx_pkg::LEN_W-1:0]  req_sat;

    // decode
    always_comb
    begin
        start_ok    = (item.func == apx_pkg::FN_START) && (phase_reg == apx_pkg::PH_IDLE);
        load_ok     = (item.func == apx_pkg::FN_LOAD) && (phase_reg == apx_pkg::PH_IDLE)
                      && (load_index_reg < apx_pkg::CNT_W'(apx_pkg::MAX_PACKET));
        xchg_ok     = (item.func == apx_pkg::FN_XCHG) && (phase_reg == apx_pkg::PH_BYTE);
        tick_ok     = (item.func == apx_pkg::FN_TICK) && (phase_reg == apx_pkg::PH_ACK);
        ack_end     = tick_ok && item.ack_seen && (rc_reg >= resp_limit_reg);
        ack_send    = tick_ok && item.ack_seen && (rc_reg < resp_limit_reg);
        timeout_end = tick_ok && !item.ack_seen
                      && (ticks_reg <= apx_pkg::TICK_W'(1));
        done        = ack_end || timeout_end;
        req_sat     = (32'(item.req_length) > apx_pkg::MAX_PACKET)
                      ? apx_pkg::LEN_W'(apx_pkg::MAX_PACKET) : item.req_length;
    end

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        load_index_next = load_index_reg;
        rc_next         = rc_reg;
        req_total_next  = req_total_reg;
        resp_limit_next = resp_limit_reg;
        ticks_next      = ticks_reg;

        case (phase_reg)
            apx_pkg::PH_IDLE:
            begin
                if (start_ok)
                begin
                    phase_next      = apx_pkg::PH_ACK;
                    rc_next         = '0;
                    req_total_next  = req_sat;
                    resp_limit_next = item.max_resp_length;
                    ticks_next      = timeout_reg;
                end
                if (load_ok)
                begin
                    load_index_next = load_index_reg + apx_pkg::CNT_W'(1);
                end
            end
            apx_pkg::PH_ACK:
            begin
                if (tick_ok)
                begin
                    if (ack_send)
                    begin
                        phase_next = apx_pkg::PH_BYTE;
                    end
                    else if (done)
                    begin
                        phase_next      = apx_pkg::PH_IDLE;
                        load_index_next = '0;
                    end
                    if (timeout_end)
                    begin
                        ticks_next = '0;
                    end
                    else if (!item.ack_seen)
                    begin
                        ticks_next = ticks_reg - apx_pkg::TICK_W'(1);
                    end
                end
            end
            apx_pkg::PH_BYTE:
            begin
                if (xchg_ok)
                begin
                    phase_next = apx_pkg::PH_ACK;
                    rc_next    = rc_reg + apx_pkg::LEN_W'(1);
                    ticks_next = timeout_reg;
                end
            end
            default:
            begin
                phase_next = apx_pkg::PH_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        result.tx_valid      = start_ok || ack_send;
        if (start_ok)
        begin
            result.tx_byte = item.device_address;
        end
        else if (ack_send && (rc_reg < req_total_reg))
        begin
            result.tx_byte = rd_data;
        end
        else
        begin
            result.tx_byte = '0;
        end
        result.resp_valid    = xchg_ok;
        result.resp_byte     = xchg_ok ? item.data_byte : '0;
        result.select_active = (phase_next != apx_pkg::PH_IDLE);
        result.done_res      = done;
        result.resp_count    = rc_next;

        store_req.we    = fire && load_ok;
        store_req.waddr = load_index_reg[apx_pkg::IDX_W-1:0];
        store_req.wdata = item.data_byte;
        // read for the next item uses the count this item leaves behind
        store_req.raddr = fire ? apx_pkg::idx_of(rc_next) : apx_pkg::idx_of(rc_reg);
    end

    assign phase = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= apx_pkg::PH_IDLE;
            load_index_reg <= '0;
            rc_reg         <= '0;
            req_total_reg  <= '0;
            resp_limit_reg <= '0;
            ticks_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            load_index_reg <= load_index_next;
            rc_reg         <= rc_next;
            req_total_reg  <= req_total_next;
            resp_limit_reg <= resp_limit_next;
            ticks_reg      <= ticks_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= apx_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

endmodule

// ----- rtl/ack_paced_packet_exchanger.sv -----
// Channel   Handshake           Payload
// in        in_valid/in_stall   func, device_address, data_byte, req_length,
//                               max_resp_length, ack_seen
// out       out_valid/out_stall tx_valid, tx_byte, resp_valid, resp_byte,
//                               select_active, done_res, resp_count
// cfg       cfg_wr_en           cfg_wr_data (ack timeout in ticks)
//
// One transaction per clock sustained while out_stall is low; each passes the execute and output registers.
// The request store read port fetches the byte for the next item when that item is
// taken, at the count left by the item in execute; a same-entry write is bypassed.
// Reset clears control and sets the timeout to 12; store contents stay undefined.
// in_stall rises only when the output register is full and out_stall is high.

`include "assert_macros.svh"

module ack_paced_packet_exchanger (
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_wr_en,
    input  logic [apx_pkg::TICK_W-1:0] cfg_wr_data,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 func,
    input  logic [apx_pkg::BYTE_W-1:0] device_address,
    input  logic [apx_pkg::BYTE_W-1:0] data_byte,
    input  logic [apx_pkg::LEN_W-1:0]  req_length,
    input  logic [apx_pkg::LEN_W-1:0]  max_resp_length,
    input  logic                       ack_seen,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       tx_valid,
    output logic [apx_pkg::BYTE_W-1:0] tx_byte,
    output logic                       resp_valid,
    output logic [apx_pkg::BYTE_W-1:0] resp_byte,
    output logic                       select_active,
    output logic                       done_res,
    output logic [apx_pkg::LEN_W-1:0]  resp_count
);

    // execute stage: one transaction, its store byte arrives alongside
    logic                 exec_valid_reg, exec_valid_next;
    apx_pkg::item_t       exec_item_reg;
    // output register
    logic                 out_valid_reg, out_valid_next;
    apx_pkg::result_t     out_result_reg;

    logic                 exec_fire;
    logic                 accept;
    apx_pkg::item_t       in_item;
    apx_pkg::result_t     exec_result;
    apx_pkg::store_req_t  store_req;
    apx_pkg::phase_t      phase;
    logic [apx_pkg::BYTE_W-1:0] rd_data;

    always_comb
    begin
        in_item.func            = apx_pkg::func_t'(func);
        in_item.device_address  = device_address;
        in_item.data_byte       = data_byte;
        in_item.req_length      = req_length;
        in_item.max_resp_length = max_resp_length;
        in_item.ack_seen        = ack_seen;
    end

    // execute retires whenever the output register is free or draining
    assign exec_fire = exec_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = exec_valid_reg && !exec_fire;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            exec_valid_next = 1'b1;
        end
        else if (exec_fire)
        begin
            exec_valid_next = 1'b0;
        end
        else
        begin
            exec_valid_next = exec_valid_reg;
        end
        out_valid_next = exec_fire || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            exec_valid_reg <= exec_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            exec_item_reg <= in_item;
        end
        if (exec_fire)
        begin
            out_result_reg <= exec_result;
        end
    end

    apx_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (exec_item_reg),
        .fire        (exec_fire),
        .rd_data     (rd_data),
        .result      (exec_result),
        .store_req   (store_req),
        .phase       (phase)
    );

    apx_store u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_en   (accept),
        .rd_data (rd_data)
    );

    assign out_valid     = out_valid_reg;
    assign tx_valid      = out_result_reg.tx_valid;
    assign tx_byte       = out_result_reg.tx_byte;
    assign resp_valid    = out_result_reg.resp_valid;
    assign resp_byte     = out_result_reg.resp_byte;
    assign select_active = out_result_reg.select_active;
    assign done_res      = out_result_reg.done_res;
    assign resp_count    = out_result_reg.resp_count;

    // a finished transaction always drops select
    `APX_ASSERT_NOW(a_done_drops_sel, out_valid_reg && out_result_reg.done_res, !out_result_reg.select_active, "done with select still high")
    // a received byte always counts
    `APX_ASSERT_NOW(a_resp_counted, out_valid_reg && out_result_reg.resp_valid, out_result_reg.resp_count != '0, "response byte not counted")
    // request bytes are only written between transactions
    `APX_ASSERT_NOW(a_load_idle, store_req.we, phase == apx_pkg::PH_IDLE, "store write while busy")
    // an accepted start moves to waiting for acknowledge
    `APX_ASSERT_NEXT(a_start_ack, exec_fire && (exec_item_reg.func == apx_pkg::FN_START) && (phase == apx_pkg::PH_IDLE), phase == apx_pkg::PH_ACK, "start did not enter ack wait")

endmodule
